/* hw/rtl/vrt_pkg.sv */
// Shared types and constants for the voxel ray traversal block.
package vrt_pkg;

	localparam int GRID_SIZE = 32;
	localparam int CW = $clog2(GRID_SIZE);
	localparam int ROWS = GRID_SIZE * GRID_SIZE;
	localparam int ROW_AW = 2 * CW;
	// Signed walk coordinate: the walk can leave the grid by a few hundred cells.
	localparam int POS_W = (CW + 2 > 12) ? CW + 2 : 12;

	localparam int T_W = 16;
	localparam logic [T_W-1:0] T_SAT = '1;
	localparam logic [7:0] MAX_DIST_RESET = 8'd20;

	localparam int DIVIDEND_W = 23;
	localparam int DIVISOR_W = 16;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic [ROW_AW-1:0] row;
		logic [GRID_SIZE-1:0] wdata;
	} mem_req_t;

endpackage

/* hw/rtl/voxel_ray_traversal_top.sv */
// Voxel ray traversal: a 32x32x32 occupancy bitmap plus a grid-stepping ray walker.
//
// The block keeps one occupancy bit per cell, all empty after reset. A write item
// (operation 0) sets or clears one cell and returns a result with every field zero.
// A cast item (operation 1) gives a ray origin in unsigned Q5.8 voxel units and a
// signed Q1.14 direction. The block first computes tMax and tDelta for each axis
// with one shared serial divider (up to six divisions), then walks the grid one
// cell per step, always advancing the axis with the smallest tMax (ties go to z,
// then y). Each step runs through advance, occupancy read and test. It reports
// the first occupied cell entered with the axis and sign of the crossed face,
// or a miss once every tMax has reached max_distance*256. Cells outside the
// grid read as empty. After reset the bitmap is cleared one row per cycle over
// all 1024 rows, during which no item transfer is taken; configuration writes
// are taken at any time. The result sits in an output register, so the next item
// can be taken while a result transfer is still pending. max_distance lives at
// APB address 0.
module voxel_ray_traversal_top (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic req_valid,
	output logic req_ready,
	input  logic operation,
	input  logic [4:0] cell_x,
	input  logic [4:0] cell_y,
	input  logic [4:0] cell_z,
	input  logic occupied,
	input  logic [12:0] origin_x,
	input  logic [12:0] origin_y,
	input  logic [12:0] origin_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic rsp_valid,
	input  logic rsp_ready,
	output logic hit,
	output logic [4:0] hit_x,
	output logic [4:0] hit_y,
	output logic [4:0] hit_z,
	output logic [1:0] normal_axis,
	output logic normal_negative
);

	localparam int CW = vrt_pkg::CW;
	localparam int PW = vrt_pkg::POS_W;
	localparam int TW = vrt_pkg::T_W;

	// Sequencer states, one-hot.
	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_WRD   = 10'b0000000100,
		S_WWR   = 10'b0000001000,
		S_DIV   = 10'b0000010000,
		S_DWAIT = 10'b0000100000,
		S_STEP  = 10'b0001000000,
		S_RD    = 10'b0010000000,
		S_CHK   = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;

	// Configuration register.
	logic [7:0] max_dist_q;

	// Latched item.
	logic occupied_q;
	logic [4:0] wcell_q [3];
	logic [15:0] dir_q [3];
	logic [7:0] frac_q [3];

	// Walk state.
	logic signed [PW-1:0] c_q [3];
	logic pos_q [3];
	logic [TW-1:0] tm_q [3];
	logic [TW-1:0] td_q [3];
	logic [2:0] idx_q;

	// Result being built and the output register.
	logic res_hit_q;
	logic [4:0] res_c_q [3];
	logic [1:0] res_axis_q;
	logic res_neg_q;
	logic rsp_valid_q;
	logic hit_q;
	logic [4:0] hit_c_q [3];
	logic [1:0] normal_axis_q;
	logic normal_neg_q;

	// Memory and divider hookup.
	vrt_pkg::mem_req_t mem_req;
	logic [vrt_pkg::GRID_SIZE-1:0] mem_rdata;
	logic clearing;
	logic div_start;
	logic div_done;
	logic [vrt_pkg::DIVIDEND_W-1:0] div_dividend;
	logic [TW-1:0] div_quot;

	// Setup datapath for the axis selected by idx_q.
	logic [1:0] su_axis;
	logic [15:0] su_dir;
	logic [15:0] su_mag;
	logic su_pos;
	logic [8:0] su_dist;

	// Step datapath.
	vrt_pkg::axis_t step_axis;
	logic [TW:0] step_sum;
	logic [TW-1:0] step_tm;
	logic [TW-1:0] limit;
	logic in_grid;
	logic cell_bit;
	logic any_below;
	logic can_out;
	logic accept;
	logic write_in_grid;
	logic [CW-1:0] wbit;

	assign pready = 1'b1;
	assign prdata = {24'd0, max_dist_q};
	assign req_ready = (state_q == S_IDLE);
	assign accept = req_valid && req_ready;
	assign can_out = !rsp_valid_q || rsp_ready;
	assign limit = {max_dist_q, 8'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q <= vrt_pkg::MAX_DIST_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			max_dist_q <= pwdata[7:0];
		end
	end

	always_comb begin
		su_axis = idx_q[2:1];
		unique case (su_axis)
			vrt_pkg::AXIS_X: su_dir = dir_q[0];
			vrt_pkg::AXIS_Y: su_dir = dir_q[1];
			default:         su_dir = dir_q[2];
		endcase
		su_mag = su_dir[15] ? (~su_dir + 16'd1) : su_dir;
		su_pos = (su_dir != 16'd0) && !su_dir[15];
		unique case (su_axis)
			vrt_pkg::AXIS_X: su_dist = su_pos ? (9'd256 - {1'b0, frac_q[0]})
				: {1'b0, frac_q[0]};
			vrt_pkg::AXIS_Y: su_dist = su_pos ? (9'd256 - {1'b0, frac_q[1]})
				: {1'b0, frac_q[1]};
			default:         su_dist = su_pos ? (9'd256 - {1'b0, frac_q[2]})
				: {1'b0, frac_q[2]};
		endcase
		// tMax numerator is dist * 16384, tDelta numerator is 256 * 16384.
		div_dividend = idx_q[0] ? 23'h400000 : {su_dist, 14'd0};
		div_start = (state_q == S_DIV) && (su_mag != 16'd0);
	end

	vrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (su_mag),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Axis choice: x only when strictly smallest, y when strictly below z and not above x, else z.
	always_comb begin
		if (tm_q[0] < tm_q[1]) begin
			step_axis = (tm_q[0] < tm_q[2]) ? vrt_pkg::AXIS_X : vrt_pkg::AXIS_Z;
		end else begin
			step_axis = (tm_q[1] < tm_q[2]) ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
		end
		unique case (step_axis)
			vrt_pkg::AXIS_X: step_sum = {1'b0, tm_q[0]} + {1'b0, td_q[0]};
			vrt_pkg::AXIS_Y: step_sum = {1'b0, tm_q[1]} + {1'b0, td_q[1]};
			default:         step_sum = {1'b0, tm_q[2]} + {1'b0, td_q[2]};
		endcase
		step_tm = step_sum[TW] ? vrt_pkg::T_SAT : step_sum[TW-1:0];
	end

	always_comb begin
		in_grid = 1'b1;
		for (int k = 0; k < 3; k++) begin
			if (c_q[k] < 0 || c_q[k] >= PW'(vrt_pkg::GRID_SIZE)) begin
				in_grid = 1'b0;
			end
		end
		cell_bit = mem_rdata[c_q[0][CW-1:0]];
		any_below = (tm_q[0] < limit) || (tm_q[1] < limit) || (tm_q[2] < limit);
		write_in_grid = ({27'd0, wcell_q[0]} < vrt_pkg::GRID_SIZE)
			&& ({27'd0, wcell_q[1]} < vrt_pkg::GRID_SIZE)
			&& ({27'd0, wcell_q[2]} < vrt_pkg::GRID_SIZE);
		wbit = CW'(wcell_q[0]);
	end

	// Memory requests: reads come from the write cell or the current walk cell.
	always_comb begin
		mem_req = '0;
		if (state_q == S_WRD) begin
			mem_req.rd_en = 1'b1;
			mem_req.row = {CW'(wcell_q[2]), CW'(wcell_q[1])};
		end else if (state_q == S_WWR) begin
			mem_req.wr_en = write_in_grid;
			mem_req.row = {CW'(wcell_q[2]), CW'(wcell_q[1])};
			mem_req.wdata = mem_rdata;
			mem_req.wdata[wbit] = occupied_q;
		end else if (state_q == S_RD) begin
			mem_req.rd_en = 1'b1;
			mem_req.row = {c_q[2][CW-1:0], c_q[1][CW-1:0]};
		end
	end

	vrt_occ_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rdata    (mem_rdata),
		.clearing (clearing)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (!clearing) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						state_q <= operation ? S_DIV : S_WRD;
					end
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: state_q <= S_DONE;
				S_DIV: begin
					if (su_mag != 16'd0) begin
						state_q <= S_DWAIT;
					end else if (idx_q == 3'd5) begin
						state_q <= S_STEP;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				S_DWAIT: begin
					if (div_done) begin
						if (idx_q == 3'd5) begin
							state_q <= S_STEP;
						end else begin
							idx_q <= idx_q + 3'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_STEP: state_q <= S_RD;
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if ((in_grid && cell_bit) || !any_below) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					if (can_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Item latch, setup results and walk registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			occupied_q <= occupied;
			wcell_q[0] <= cell_x;
			wcell_q[1] <= cell_y;
			wcell_q[2] <= cell_z;
			dir_q[0] <= dir_x;
			dir_q[1] <= dir_y;
			dir_q[2] <= dir_z;
			frac_q[0] <= origin_x[7:0];
			frac_q[1] <= origin_y[7:0];
			frac_q[2] <= origin_z[7:0];
			c_q[0] <= PW'(origin_x[12:8]);
			c_q[1] <= PW'(origin_y[12:8]);
			c_q[2] <= PW'(origin_z[12:8]);
			res_hit_q <= 1'b0;
			res_c_q[0] <= '0;
			res_c_q[1] <= '0;
			res_c_q[2] <= '0;
			res_axis_q <= '0;
			res_neg_q <= 1'b0;
		end
		if (state_q == S_DIV) begin
			pos_q[su_axis] <= su_pos;
			if (su_mag == 16'd0) begin
				if (idx_q[0]) begin
					td_q[su_axis] <= vrt_pkg::T_SAT;
				end else begin
					tm_q[su_axis] <= vrt_pkg::T_SAT;
				end
			end
		end
		if (state_q == S_DWAIT && div_done) begin
			if (idx_q[0]) begin
				td_q[su_axis] <= div_quot;
			end else begin
				tm_q[su_axis] <= div_quot;
			end
		end
		if (state_q == S_STEP) begin
			tm_q[step_axis] <= step_tm;
			c_q[step_axis] <= pos_q[step_axis] ? c_q[step_axis] + PW'(1)
				: c_q[step_axis] - PW'(1);
			res_axis_q <= step_axis;
			res_neg_q <= pos_q[step_axis];
		end
		if (state_q == S_CHK && in_grid && cell_bit) begin
			res_hit_q <= 1'b1;
			res_c_q[0] <= 5'(c_q[0]);
			res_c_q[1] <= 5'(c_q[1]);
			res_c_q[2] <= 5'(c_q[2]);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && can_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && can_out) begin
			hit_q <= res_hit_q;
			hit_c_q[0] <= res_c_q[0];
			hit_c_q[1] <= res_c_q[1];
			hit_c_q[2] <= res_c_q[2];
			normal_axis_q <= res_hit_q ? res_axis_q : 2'd0;
			normal_neg_q <= res_hit_q && res_neg_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit = hit_q;
	assign hit_x = hit_c_q[0];
	assign hit_y = hit_c_q[1];
	assign hit_z = hit_c_q[2];
	assign normal_axis = normal_axis_q;
	assign normal_negative = normal_neg_q;

endmodule

/* hw/rtl/vrt_occ_mem.sv */
// Occupancy bitmap memory, one row of cells per (y, z), with a clearing sweep after reset.
module vrt_occ_mem (
	input  logic clk,
	input  logic arst_n,
	input  vrt_pkg::mem_req_t req,
	output logic [vrt_pkg::GRID_SIZE-1:0] rdata,
	output logic clearing
);

	logic [vrt_pkg::GRID_SIZE-1:0] mem [vrt_pkg::ROWS];
	logic [vrt_pkg::GRID_SIZE-1:0] rdata_q;
	logic [vrt_pkg::ROW_AW-1:0] clr_row_q;
	logic clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_row_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.row] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.row];
		end
	end

	assign rdata = rdata_q;
	assign clearing = clearing_q;

endmodule

/* hw/rtl/vrt_div.sv */
// Restoring divider, one quotient bit per cycle, with a saturated 16-bit quotient.
module vrt_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [vrt_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [vrt_pkg::DIVISOR_W-1:0] divisor,
	output logic done,
	output logic [vrt_pkg::T_W-1:0] quotient
);

	localparam int CNT_W = $clog2(vrt_pkg::DIVIDEND_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [vrt_pkg::DIVISOR_W:0] rem_q;
	logic [vrt_pkg::DIVIDEND_W-1:0] quo_q;
	logic [vrt_pkg::DIVISOR_W:0] rem_sh;
	logic [vrt_pkg::DIVISOR_W+1:0] diff;

	always_comb begin
		rem_sh = {rem_q[vrt_pkg::DIVISOR_W-1:0], quo_q[vrt_pkg::DIVIDEND_W-1]};
		diff = {1'b0, rem_sh} - {2'b00, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(vrt_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[vrt_pkg::DIVISOR_W+1]) begin
				rem_q <= diff[vrt_pkg::DIVISOR_W:0];
				quo_q <= {quo_q[vrt_pkg::DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[vrt_pkg::DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = (|quo_q[vrt_pkg::DIVIDEND_W-1:vrt_pkg::T_W]) ? vrt_pkg::T_SAT
		: quo_q[vrt_pkg::T_W-1:0];

endmodule
